// ----- rtl/core/line_sensor_centroid_tracker_defines.svh -----
// Assertion macros shared by the line sensor centroid tracker RTL.
`ifndef LINE_SENSOR_CENTROID_TRACKER_DEFINES_SVH
`define LINE_SENSOR_CENTROID_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define LSCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define LSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lsct_pkg.sv -----
// Widths, limits, track codes and the sensor weight table of the centroid tracker.
package lsct_pkg;

    localparam int SENSORS    = 8;
    localparam int IDX_W      = $clog2(SENSORS);
    localparam int TAG_W      = 16;
    localparam int MASK_W     = 8;
    localparam int STRENGTH_W = 10;
    localparam int COUNT_W    = 4;
    localparam int SUM_W      = 13;
    localparam int SUMRAW_W   = 14;
    localparam int POS_W      = 14;
    localparam int ACC_W      = 25;
    localparam int MAG_W      = 24;
    localparam int CNT_W      = 5;
    localparam int DIV_STEPS  = MAG_W;

    localparam logic [SUM_W-1:0] STRENGTH_CAP = 13'd8000;
    localparam logic [MAG_W-1:0] POS_LIMIT    = 24'd7000;

    localparam logic [1:0] TRK_NORMAL    = 2'd0;
    localparam logic [1:0] TRK_LOST      = 2'd1;
    localparam logic [1:0] TRK_ALL_BLACK = 2'd2;
    localparam logic [1:0] TRK_INVALID   = 2'd3;

    function automatic logic signed [POS_W-1:0] sensor_weight(input logic [IDX_W-1:0] idx);
        logic signed [POS_W-1:0] w;
        case (idx)
            3'd0:    w = -14'sd7000;
            3'd1:    w = -14'sd5000;
            3'd2:    w = -14'sd3000;
            3'd3:    w = -14'sd1000;
            3'd4:    w = 14'sd1000;
            3'd5:    w = 14'sd3000;
            3'd6:    w = 14'sd5000;
            default: w = 14'sd7000;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/line_sensor_centroid_tracker.sv -----
// A normal frame runs the 8-step multiply-accumulate, a check state, the 24-step
// restoring divider and a fix-up state before its result is loaded into the output
// register; lost or all-black frames skip the divider, invalid frames skip all of it.
// Frames are taken only while idle, and a result waits while the output slot is occupied.
// A new frame is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the sequencer, output valid and the held position.
`include "line_sensor_centroid_tracker_defines.svh"

module line_sensor_centroid_tracker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [lsct_pkg::TAG_W-1:0]             i_frame_tag,
    input  logic [lsct_pkg::MASK_W-1:0]            i_valid_bits,
    input  logic [lsct_pkg::MASK_W-1:0]            i_black_bits,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_0,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_1,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_2,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_3,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_4,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_5,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_6,
    input  logic [lsct_pkg::STRENGTH_W-1:0]        i_strength_7,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [lsct_pkg::TAG_W-1:0]             o_result_tag,
    output logic [1:0]                             o_track_state,
    output logic [lsct_pkg::MASK_W-1:0]            o_black_echo,
    output logic [lsct_pkg::COUNT_W-1:0]           o_black_total,
    output logic [lsct_pkg::SUM_W-1:0]             o_strength_total,
    output logic signed [lsct_pkg::POS_W-1:0]      o_line_position,
    output logic signed [lsct_pkg::POS_W-1:0]      o_steer_error
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } t_state;

    t_state r_state, n_state;

    logic [lsct_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic [lsct_pkg::TAG_W-1:0]           r_tag, n_tag;
    logic [lsct_pkg::MASK_W-1:0]          r_black, n_black;
    logic [lsct_pkg::COUNT_W-1:0]         r_blacks, n_blacks;
    logic [lsct_pkg::STRENGTH_W-1:0]      r_str [lsct_pkg::SENSORS];
    logic [lsct_pkg::STRENGTH_W-1:0]      n_str [lsct_pkg::SENSORS];
    logic [lsct_pkg::SUMRAW_W-1:0]        r_sum, n_sum;
    logic signed [lsct_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [lsct_pkg::SUM_W-1:0]           r_sum_cl, n_sum_cl;
    logic [lsct_pkg::SUMRAW_W-1:0]        r_rem, n_rem;
    logic [lsct_pkg::MAG_W-1:0]           r_quo, n_quo;
    logic                                 r_neg, n_neg;
    logic [1:0]                           r_res_state, n_res_state;
    logic signed [lsct_pkg::POS_W-1:0]    r_res_pos, n_res_pos;
    logic signed [lsct_pkg::POS_W-1:0]    r_last_pos, n_last_pos;

    logic                                 r_out_valid, n_out_valid;
    logic [lsct_pkg::TAG_W-1:0]           r_o_tag, n_o_tag;
    logic [1:0]                           r_o_state, n_o_state;
    logic [lsct_pkg::MASK_W-1:0]          r_o_black, n_o_black;
    logic [lsct_pkg::COUNT_W-1:0]         r_o_blacks, n_o_blacks;
    logic [lsct_pkg::SUM_W-1:0]           r_o_sum, n_o_sum;
    logic signed [lsct_pkg::POS_W-1:0]    r_o_pos, n_o_pos;

    logic                                 w_in_acc;
    logic [lsct_pkg::COUNT_W-1:0]         w_pop;
    logic signed [lsct_pkg::POS_W-1:0]    w_wt;
    logic signed [lsct_pkg::STRENGTH_W:0] w_s;
    logic signed [lsct_pkg::ACC_W-1:0]    w_prod;
    logic [lsct_pkg::SUM_W-1:0]           w_sum_cl;
    logic [lsct_pkg::MAG_W-1:0]           w_mag;
    logic [lsct_pkg::SUMRAW_W-1:0]        w_trial;
    logic [lsct_pkg::SUMRAW_W-1:0]        w_dvs;
    logic [lsct_pkg::SUMRAW_W-1:0]        w_diff;
    logic                                 w_ge;
    logic [lsct_pkg::MAG_W-1:0]           w_qsat;
    logic [lsct_pkg::POS_W-1:0]           w_qmag;
    logic signed [lsct_pkg::POS_W-1:0]    w_fix_pos;

    assign o_in_ready       = (r_state == ST_IDLE);
    assign w_in_acc         = i_in_valid && o_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_result_tag     = r_o_tag;
    assign o_track_state    = r_o_state;
    assign o_black_echo     = r_o_black;
    assign o_black_total    = r_o_blacks;
    assign o_strength_total = r_o_sum;
    assign o_line_position  = r_o_pos;
    assign o_steer_error    = r_o_pos;

    always_comb begin
        w_pop = '0;
        for (int k = 0; k < lsct_pkg::SENSORS; k++) begin
            w_pop = w_pop + lsct_pkg::COUNT_W'(i_black_bits[k]);
        end
    end

    // Shared multiply-accumulate: the head of the strength shift line times its weight.
    assign w_wt   = lsct_pkg::sensor_weight(r_cnt[lsct_pkg::IDX_W-1:0]);
    assign w_s    = $signed({1'b0, r_str[0]});
    assign w_prod = w_wt * w_s;

    assign w_sum_cl = (r_sum > lsct_pkg::SUMRAW_W'(lsct_pkg::STRENGTH_CAP))
                      ? lsct_pkg::STRENGTH_CAP : r_sum[lsct_pkg::SUM_W-1:0];
    assign w_mag    = r_acc[lsct_pkg::ACC_W-1] ? lsct_pkg::MAG_W'(-r_acc)
                                               : lsct_pkg::MAG_W'(r_acc);

    // Restoring divider step: one quotient bit per cycle.
    assign w_trial = {r_rem[lsct_pkg::SUM_W-1:0], r_quo[lsct_pkg::MAG_W-1]};
    assign w_dvs   = {1'b0, r_sum_cl};
    assign w_diff  = w_trial - w_dvs;
    assign w_ge    = (w_trial >= w_dvs);

    assign w_qsat    = (r_quo > lsct_pkg::POS_LIMIT) ? lsct_pkg::POS_LIMIT : r_quo;
    assign w_qmag    = w_qsat[lsct_pkg::POS_W-1:0];
    assign w_fix_pos = r_neg ? $signed(~w_qmag + 1'b1) : $signed(w_qmag);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tag       = r_tag;
        n_black     = r_black;
        n_blacks    = r_blacks;
        n_str       = r_str;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_sum_cl    = r_sum_cl;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_res_state = r_res_state;
        n_res_pos   = r_res_pos;
        n_last_pos  = r_last_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_tag     = r_o_tag;
        n_o_state   = r_o_state;
        n_o_black   = r_o_black;
        n_o_blacks  = r_o_blacks;
        n_o_sum     = r_o_sum;
        n_o_pos     = r_o_pos;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_tag    = i_frame_tag;
                    n_black  = i_black_bits;
                    n_blacks = w_pop;
                    n_str[0] = i_strength_0;
                    n_str[1] = i_strength_1;
                    n_str[2] = i_strength_2;
                    n_str[3] = i_strength_3;
                    n_str[4] = i_strength_4;
                    n_str[5] = i_strength_5;
                    n_str[6] = i_strength_6;
                    n_str[7] = i_strength_7;
                    n_sum    = '0;
                    n_acc    = '0;
                    n_cnt    = '0;
                    if (&i_valid_bits) begin
                        n_state = ST_ACC;
                    end else begin
                        n_res_state = lsct_pkg::TRK_INVALID;
                        n_sum_cl    = '0;
                        n_res_pos   = '0;
                        n_state     = ST_OUT;
                    end
                end
            end
            ST_ACC: begin
                n_sum = r_sum + lsct_pkg::SUMRAW_W'(r_str[0]);
                n_acc = r_acc + w_prod;
                // advance the shift line so the next sensor sits at the head
                for (int k = 0; k < lsct_pkg::SENSORS - 1; k++) begin
                    n_str[k] = r_str[k+1];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lsct_pkg::CNT_W'(lsct_pkg::SENSORS - 1)) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                n_sum_cl = w_sum_cl;
                if (&r_black) begin
                    n_res_state = lsct_pkg::TRK_ALL_BLACK;
                    n_res_pos   = '0;
                    n_state     = ST_OUT;
                end else if ((r_blacks == '0) || (w_sum_cl == '0)) begin
                    n_res_state = lsct_pkg::TRK_LOST;
                    n_res_pos   = r_last_pos;
                    n_state     = ST_OUT;
                end else begin
                    n_rem   = '0;
                    n_quo   = w_mag;
                    n_neg   = r_acc[lsct_pkg::ACC_W-1];
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_diff : w_trial;
                n_quo = {r_quo[lsct_pkg::MAG_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lsct_pkg::CNT_W'(lsct_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_res_state = lsct_pkg::TRK_NORMAL;
                n_res_pos   = w_fix_pos;
                n_last_pos  = w_fix_pos;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_tag     = r_tag;
                    n_o_state   = r_res_state;
                    n_o_black   = r_black;
                    n_o_blacks  = r_blacks;
                    n_o_sum     = r_sum_cl;
                    n_o_pos     = r_res_pos;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_last_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last_pos  <= n_last_pos;
            r_out_valid <= n_out_valid;
        end
        r_tag       <= n_tag;
        r_black     <= n_black;
        r_blacks    <= n_blacks;
        r_str       <= n_str;
        r_sum       <= n_sum;
        r_acc       <= n_acc;
        r_sum_cl    <= n_sum_cl;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_neg       <= n_neg;
        r_res_state <= n_res_state;
        r_res_pos   <= n_res_pos;
        r_o_tag     <= n_o_tag;
        r_o_state   <= n_o_state;
        r_o_black   <= n_o_black;
        r_o_blacks  <= n_o_blacks;
        r_o_sum     <= n_o_sum;
        r_o_pos     <= n_o_pos;
    end

    `LSCT_ASSERT_NOW(a_invalid_zero,
        o_out_valid && (o_track_state == lsct_pkg::TRK_INVALID),
        (o_strength_total == '0) && (o_line_position == '0),
        "invalid frame result not zeroed")
    `LSCT_ASSERT_NOW(a_all_black_mask,
        o_out_valid && (o_track_state == lsct_pkg::TRK_ALL_BLACK),
        (o_black_echo == 8'hFF) && (o_line_position == '0),
        "all-black result inconsistent")
    `LSCT_ASSERT_NOW(a_pos_range, o_out_valid,
        (o_line_position <= 14'sd7000) && (o_line_position >= -14'sd7000),
        "line position out of range")
    `LSCT_ASSERT_NOW(a_sum_cap, o_out_valid,
        o_strength_total <= lsct_pkg::STRENGTH_CAP, "strength total above cap")
    `LSCT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "ready stayed high after a frame transaction")

endmodule
